>>> src/gpe_pkg.sv
// Package for the GPIO port: item types, command codes, register offsets.
package gpe_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int PIN_COUNT_DEFAULT = 16;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   localparam logic [3:0] OFS_ID     = 4'h0;
   localparam logic [3:0] OFS_DIR    = 4'h2;
   localparam logic [3:0] OFS_VALUE  = 4'h4;
   localparam logic [3:0] OFS_ENABLE = 4'h6;
   localparam logic [3:0] OFS_STATUS = 4'h8;
   localparam logic [3:0] OFS_EDGE   = 4'hA;

   typedef struct packed {
      logic [1:0]            command;
      logic [3:0]            address;
      logic [DATA_WIDTH-1:0] write_data;
      logic [DATA_WIDTH-1:0] pins_in;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [DATA_WIDTH-1:0] pins_out;
      logic [DATA_WIDTH-1:0] pins_drive_enable;
      logic                  irq;
   } rsp_type;

endpackage

>>> src/gpe_core.sv
// Port registers, edge detection and result formation for one item.
module gpe_core #(
   parameter int PIN_COUNT = gpe_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  gpe_pkg::req_type              item,
   input  logic [gpe_pkg::DATA_WIDTH-1:0] device_id,
   output gpe_pkg::rsp_type              result
);

   logic [PIN_COUNT-1:0] dir_ff, dir_in;
   logic [PIN_COUNT-1:0] latch_ff, latch_in;
   logic [PIN_COUNT-1:0] enable_ff, enable_in;
   logic [PIN_COUNT-1:0] pending_ff, pending_in;
   logic [PIN_COUNT-1:0] edge_ff, edge_in;
   logic [PIN_COUNT-1:0] prev_ff, prev_in;

   logic [PIN_COUNT-1:0] pins;
   logic [PIN_COUNT-1:0] wdata;
   logic [PIN_COUNT-1:0] rise;
   logic [PIN_COUNT-1:0] fall;
   logic [PIN_COUNT-1:0] hit;
   logic [PIN_COUNT-1:0] drive_en;
   logic [gpe_pkg::DATA_WIDTH-1:0] read_data;

   assign pins  = item.pins_in[PIN_COUNT-1:0];
   assign wdata = item.write_data[PIN_COUNT-1:0];
   assign rise  = pins & ~prev_ff;
   assign fall  = prev_ff & ~pins;
   assign hit   = (rise & edge_ff) | (fall & ~edge_ff);
   // inverted at pin width so bits above the pin count stay zero
   assign drive_en = ~dir_in;

   always_comb begin
      dir_in     = dir_ff;
      latch_in   = latch_ff;
      enable_in  = enable_ff;
      pending_in = pending_ff;
      edge_in    = edge_ff;
      prev_in    = prev_ff;
      read_data  = '0;
      case (item.command)
         gpe_pkg::CMD_READ: begin
            case (item.address)
               gpe_pkg::OFS_ID:     read_data = device_id;
               gpe_pkg::OFS_DIR:    read_data = gpe_pkg::DATA_WIDTH'(dir_ff);
               gpe_pkg::OFS_VALUE:  read_data = gpe_pkg::DATA_WIDTH'(
                                       (pins & dir_ff) | (latch_ff & ~dir_ff));
               gpe_pkg::OFS_ENABLE: read_data = gpe_pkg::DATA_WIDTH'(enable_ff);
               gpe_pkg::OFS_STATUS: read_data = gpe_pkg::DATA_WIDTH'(pending_ff);
               gpe_pkg::OFS_EDGE:   read_data = gpe_pkg::DATA_WIDTH'(edge_ff);
               default:             read_data = '0;
            endcase
         end
         gpe_pkg::CMD_WRITE: begin
            case (item.address)
               gpe_pkg::OFS_DIR:    dir_in     = wdata;
               gpe_pkg::OFS_VALUE:  latch_in   = wdata;
               gpe_pkg::OFS_ENABLE: enable_in  = wdata;
               // write-one-to-clear
               gpe_pkg::OFS_STATUS: pending_in = pending_ff & ~wdata;
               gpe_pkg::OFS_EDGE:   edge_in    = wdata;
               default: ;
            endcase
         end
         gpe_pkg::CMD_SAMPLE: begin
            pending_in = pending_ff | hit;
            prev_in    = pins;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.read_data         = read_data;
      result.pins_out          = gpe_pkg::DATA_WIDTH'(latch_in);
      result.pins_drive_enable = gpe_pkg::DATA_WIDTH'(drive_en);
      result.irq               = |(pending_in & enable_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= '1;
         latch_ff   <= '0;
         enable_ff  <= '0;
         pending_ff <= '0;
         edge_ff    <= '0;
         prev_ff    <= '0;
      end else if (fire) begin
         dir_ff     <= dir_in;
         latch_ff   <= latch_in;
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
         edge_ff    <= edge_in;
         prev_ff    <= prev_in;
      end
   end

endmodule

>>> src/gpio_port_with_edge_interrupts.sv
// GPIO port with edge interrupts: top level with input and result registers.
// Each item (bus read, bus write or pin-sample tick) lands in an input
// register, is applied to the port registers when the output register can take
// its result and yields one result item into that output register; one item
// is accepted every clock while the result side keeps up. The result carries
// read data plus the output latch, drive enables and irq after the update.
// The user must write device_id through the csr port only while no item is in flight; the block does not enforce this.
module gpio_port_with_edge_interrupts #(
   parameter int PIN_COUNT = gpe_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gpe_pkg::req_type              req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gpe_pkg::rsp_type              rsp_item,
   input  logic                          csr_write_enable,
   input  logic [gpe_pkg::DATA_WIDTH-1:0] csr_write_data
);

   logic                           in_valid_ff, in_valid_in;
   gpe_pkg::req_type               in_item_ff;
   logic                           out_valid_ff, out_valid_in;
   gpe_pkg::rsp_type               out_item_ff;
   logic [gpe_pkg::DATA_WIDTH-1:0] device_id_ff;
   gpe_pkg::rsp_type               result;
   logic                           advance;
   logic                           take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   gpe_core #(
      .PIN_COUNT (PIN_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .device_id (device_id_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         device_id_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            device_id_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
